FILE: hdl/peak_envelope_block_maxima_top_defines.svh
// Assertion macros for the peak envelope block maxima checker.
// Depends on nothing; included by the checker file.
`ifndef PEAK_ENVELOPE_BLOCK_MAXIMA_TOP_DEFINES_SVH
`define PEAK_ENVELOPE_BLOCK_MAXIMA_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PEB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PEB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/peb_pkg.sv
// Shared widths, reset values, register codes and types of the peak envelope block.
// No dependencies; every file but the defines header imports it.
package peb_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int MAX_BLOCK    = 4096;

   localparam int SAMPLE_W = 16;
   localparam int CH_W     = 3;
   localparam int MAG_W    = 16;
   localparam int ENV_W    = 32;
   localparam int COEF_W   = 24;
   localparam int BLEN_W   = 13;
   localparam int NCH_W    = 4;
   localparam int CNT_W    = 12;
   localparam int MAXS_W   = 15;
   localparam int MAXE_W   = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [COEF_W-1:0] ATTACK_RESET  = COEF_W'(83488);
   localparam logic [COEF_W-1:0] RELEASE_RESET = COEF_W'(558);
   localparam logic [BLEN_W-1:0] BLEN_RESET    = BLEN_W'(512);
   localparam logic [NCH_W-1:0]  NCH_RESET     = NCH_W'(2);
   localparam logic [BLEN_W-1:0] BLOCK_CAP     = BLEN_W'(MAX_BLOCK);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTACK    = 3'd0,
      CSR_RELEASE   = 3'd1,
      CSR_BLOCK_LEN = 3'd2,
      CSR_NUM_CH    = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] attack_coeff;
      logic [COEF_W-1:0] release_coeff;
      logic [BLEN_W-1:0] block_length;
      logic [NCH_W-1:0]  num_channels;
   } cfg_type;

endpackage

FILE: hdl/peb_ifs.sv
// Channel interfaces of the peak envelope block: sample input, block result, register writes.
// Depends on peb_pkg.
interface peb_req_if;
   import peb_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic [CH_W-1:0]            channel;
   modport source (output valid, output sample, output channel, input ready);
   modport sink   (input valid, input sample, input channel, output ready);
endinterface

interface peb_rsp_if;
   import peb_pkg::*;
   logic              valid;
   logic              ready;
   logic [CH_W-1:0]   out_channel;
   logic [MAXS_W-1:0] max_sample;
   logic [MAXE_W-1:0] max_envelope;
   modport source (output valid, output out_channel, output max_sample,
                   output max_envelope, input ready);
   modport sink   (input valid, input out_channel, input max_sample,
                   input max_envelope, output ready);
endinterface

interface peb_csr_if;
   import peb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/peak_envelope_block_maxima_top.sv
// Peak envelope follower with per-channel block maxima, top level.
// Depends on peb_pkg, peb_ifs, peb_csr and peb_core.
//
// Usage:
//   req_if carries one word per audio sample: a signed 16-bit sample and a
//   3-bit channel tag. Tags at or above num_channels are dropped silently.
//   rsp_if carries one word each time a channel has seen block_length
//   samples: the channel, the largest sample of the block (floored at zero)
//   and the integer part of the largest Q16.16 envelope of the block.
//   csr_if writes attack_coeff, release_coeff, block_length and num_channels
//   (indexes 0 to 3); it is always ready and should be used while idle.
//   Throughput is one sample per cycle while rsp_if does not stall, set by
//   the read, update and write-back of the channel state through a single
//   25x32 multiplier. A sample that finishes a block passes through the
//   input register and then the result register, where its word is valid.
//   Reset restores the register defaults and clears envelopes, maxima and
//   sample counts of all channels at once; no clearing sweep follows.
//   When rsp_if stalls, its word holds; samples that finish no block keep
//   flowing, and a sample that finishes a block waits in the input register
//   with req_if.ready low until the pending word is taken.
module peak_envelope_block_maxima_top (
   input logic       clock,
   input logic       reset,
   peb_req_if.sink   req_if,
   peb_rsp_if.source rsp_if,
   peb_csr_if.sink   csr_if
);
   import peb_pkg::*;

   cfg_type cfg;

   peb_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   peb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

FILE: hdl/peb_env_unit.sv
// Next-envelope arithmetic: one attack or release step on a Q16.16 envelope.
// Depends on peb_pkg.
module peb_env_unit (
   input  logic [peb_pkg::ENV_W-1:0]  env,
   input  logic [peb_pkg::MAG_W-1:0]  mag,
   input  logic [peb_pkg::COEF_W-1:0] attack_coeff,
   input  logic [peb_pkg::COEF_W-1:0] release_coeff,
   output logic [peb_pkg::ENV_W-1:0]  env_next
);
   import peb_pkg::*;

   localparam int COEF_X_W = COEF_W + 1;
   localparam int PROD_W   = COEF_X_W + ENV_W;

   logic [ENV_W-1:0]    mag_q;
   logic                decay;
   logic [COEF_X_W-1:0] coef;
   logic [ENV_W-1:0]    opnd;
   logic [PROD_W-1:0]   prod;
   logic [ENV_W-1:0]    step;

   // The attack form a*M + (2^24-a)*E equals E*2^24 + a*(M-E), so both branches
   // share a single multiplier and the attack adds the scaled gap back onto E.
   always_comb begin
      mag_q = {mag, 16'b0};
      decay = env > mag_q;
      if (decay) begin
         coef = (COEF_X_W'(1) << COEF_W) - {1'b0, release_coeff};
         opnd = env;
      end else begin
         coef = {1'b0, attack_coeff};
         opnd = mag_q - env;
      end
      prod = PROD_W'(coef) * PROD_W'(opnd);
      step = prod[COEF_W +: ENV_W];
      env_next = decay ? step : env + step;
   end

endmodule

FILE: hdl/peb_csr.sv
// Configuration registers of the peak envelope block, written through the register channel.
// Depends on peb_pkg and peb_ifs.
module peb_csr (
   input  logic             clock,
   input  logic             reset,
   peb_csr_if.sink          csr_if,
   output peb_pkg::cfg_type cfg
);
   import peb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_ATTACK:    cfg_in.attack_coeff  = csr_if.data[COEF_W-1:0];
            CSR_RELEASE:   cfg_in.release_coeff = csr_if.data[COEF_W-1:0];
            CSR_BLOCK_LEN: cfg_in.block_length  = csr_if.data[BLEN_W-1:0];
            CSR_NUM_CH:    cfg_in.num_channels  = csr_if.data[NCH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_coeff  <= ATTACK_RESET;
         cfg_ff.release_coeff <= RELEASE_RESET;
         cfg_ff.block_length  <= BLEN_RESET;
         cfg_ff.num_channels  <= NCH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/peb_core.sv
// Input register, per-channel envelope and block state, and result register.
// Depends on peb_pkg, peb_ifs and peb_env_unit.
module peb_core (
   input  logic             clock,
   input  logic             reset,
   input  peb_pkg::cfg_type cfg,
   peb_req_if.sink          req_if,
   peb_rsp_if.source        rsp_if
);
   import peb_pkg::*;

   // Input register
   logic                       in_valid_ff;
   logic                       in_valid_in;
   logic signed [SAMPLE_W-1:0] in_sample_ff;
   logic [CH_W-1:0]            in_channel_ff;

   // Per-channel state
   logic [ENV_W-1:0]  env_ff       [MAX_CHANNELS];
   logic [MAXS_W-1:0] max_smp_ff   [MAX_CHANNELS];
   logic [ENV_W-1:0]  max_env_ff   [MAX_CHANNELS];
   logic [CNT_W-1:0]  count_ff     [MAX_CHANNELS];

   // Result register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [CH_W-1:0]   rsp_channel_ff;
   logic [MAXS_W-1:0] rsp_max_smp_ff;
   logic [MAXE_W-1:0] rsp_max_env_ff;

   logic              accept;
   logic              out_free;
   logic              active;
   logic              negative;
   logic [MAG_W-1:0]  mag;
   logic [BLEN_W-1:0] eff_len;
   logic [BLEN_W-1:0] count_inc;
   logic              done;
   logic              emit;
   logic              fire;
   logic [ENV_W-1:0]  env_in;
   logic [MAXS_W-1:0] max_smp_in;
   logic [ENV_W-1:0]  max_env_in;
   logic [CNT_W-1:0]  count_in;

   peb_env_unit u_env_unit (
      .env           (env_ff[in_channel_ff]),
      .mag           (mag),
      .attack_coeff  (cfg.attack_coeff),
      .release_coeff (cfg.release_coeff),
      .env_next      (env_in)
   );

   always_comb begin
      active   = (NCH_W'(in_channel_ff) < cfg.num_channels)
                 && (int'(in_channel_ff) < MAX_CHANNELS);
      negative = in_sample_ff[SAMPLE_W-1];
      mag      = negative ? (MAG_W'(0) - MAG_W'(in_sample_ff)) : MAG_W'(in_sample_ff);

      if (cfg.block_length == '0) begin
         eff_len = BLEN_W'(1);
      end else if (cfg.block_length > BLOCK_CAP) begin
         eff_len = BLOCK_CAP;
      end else begin
         eff_len = cfg.block_length;
      end
      count_inc = BLEN_W'(count_ff[in_channel_ff]) + BLEN_W'(1);
      done      = count_inc >= eff_len;
      emit      = active && done;

      // An item that completes no block never waits for the result side.
      out_free = !rsp_valid_ff || rsp_if.ready;
      fire     = in_valid_ff && (!emit || out_free);
      accept   = req_if.valid && req_if.ready;

      if (!negative && (in_sample_ff[MAXS_W-1:0] > max_smp_ff[in_channel_ff])) begin
         max_smp_in = in_sample_ff[MAXS_W-1:0];
      end else begin
         max_smp_in = max_smp_ff[in_channel_ff];
      end
      max_env_in = (env_in > max_env_ff[in_channel_ff]) ? env_in : max_env_ff[in_channel_ff];
      count_in   = count_inc[CNT_W-1:0];

      in_valid_in  = accept || (in_valid_ff && !fire);
      rsp_valid_in = (fire && emit) || (rsp_valid_ff && !rsp_if.ready);
   end

   assign req_if.ready        = !in_valid_ff || fire;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_channel  = rsp_channel_ff;
   assign rsp_if.max_sample   = rsp_max_smp_ff;
   assign rsp_if.max_envelope = rsp_max_env_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_sample_ff  <= req_if.sample;
         in_channel_ff <= req_if.channel;
      end
      if (fire && emit) begin
         rsp_channel_ff <= in_channel_ff;
         rsp_max_smp_ff <= max_smp_in;
         rsp_max_env_ff <= max_env_in[ENV_W-1 -: MAXE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            env_ff[i]     <= '0;
            max_smp_ff[i] <= '0;
            max_env_ff[i] <= '0;
            count_ff[i]   <= '0;
         end
      end else if (fire && active) begin
         env_ff[in_channel_ff] <= env_in;
         if (emit) begin
            max_smp_ff[in_channel_ff] <= '0;
            max_env_ff[in_channel_ff] <= '0;
            count_ff[in_channel_ff]   <= '0;
         end else begin
            max_smp_ff[in_channel_ff] <= max_smp_in;
            max_env_ff[in_channel_ff] <= max_env_in;
            count_ff[in_channel_ff]   <= count_in;
         end
      end
   end

endmodule

FILE: hdl/peb_checker.sv
// Port-level checks of the peak envelope block and the bind that attaches them.
// Depends on peb_pkg and peak_envelope_block_maxima_top_defines.svh.
`include "peak_envelope_block_maxima_top_defines.svh"

module peb_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [peb_pkg::CH_W-1:0]   rsp_out_channel,
   input logic [peb_pkg::MAXS_W-1:0] rsp_max_sample,
   input logic [peb_pkg::MAXE_W-1:0] rsp_max_envelope
);
   import peb_pkg::*;

   logic req_taken;
   logic rsp_stall;

   assign req_taken = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   `PEB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid,
      "result word dropped while stalled")

   `PEB_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall,
      $stable(rsp_out_channel) && $stable(rsp_max_sample) && $stable(rsp_max_envelope),
      "result word changed while stalled")

   // A fresh result always comes from a sample taken through the input register.
   `PEB_ASSERT_SAME(a_rsp_origin, clock, reset, $rose(rsp_valid), $past($past(req_taken)),
      "result word appeared without a matching input word")

   // With the result side draining, the input side never blocks.
   `PEB_ASSERT_SAME(a_no_block, clock, reset, rsp_ready, req_ready,
      "input stalled although the result side is ready")

endmodule

bind peak_envelope_block_maxima_top peb_checker u_peb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_out_channel  (rsp_if.out_channel),
   .rsp_max_sample   (rsp_if.max_sample),
   .rsp_max_envelope (rsp_if.max_envelope)
);
